// ===== design/frgcd_pkg.sv =====
package frgcd_pkg;

    // operand width of numerator and denominator
    localparam int DATA_WIDTH = 32;

    // width of the divider bit counter
    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] word_t;

endpackage

// ===== design/frgcd_div.sv =====
module frgcd_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  frgcd_pkg::word_t     dividend,
    input  frgcd_pkg::word_t     divisor,
    output logic                 done,
    output frgcd_pkg::word_t     quotient,
    output frgcd_pkg::word_t     remainder
);
    import frgcd_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    word_t             rem_reg, rem_next;
    word_t             quo_reg, quo_next;
    word_t             dvs_reg, dvs_next;

    logic [DATA_WIDTH:0] rem_shift;
    logic [DATA_WIDTH:0] diff;

    // one restoring shift-subtract step per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            if (diff[DATA_WIDTH])
            begin
                rem_next = rem_shift[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/fraction_reduce_gcd_top.sv =====
// Reduces a signed fraction to lowest terms. A transaction is taken on a clock edge with start
// high and busy low; the result appears on the output ports for exactly one cycle with done
// high, and the receiver must take it then since it cannot stall the block. A zero
// denominator passes the numerator through with zero_denominator set, and its result appears
// in the cycle after start. Otherwise one shared radix-2 divider does all the work: each
// Euclid remainder step uses it, then two exact divisions of the numerator and denominator
// magnitudes by the gcd follow, so the length of a transaction is set by the number of Euclid
// steps. Busy stays high for the whole computation and no new transaction is taken meanwhile.
module fraction_reduce_gcd_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [frgcd_pkg::DATA_WIDTH-1:0] numerator_in,
    input  logic signed [frgcd_pkg::DATA_WIDTH-1:0] denominator_in,
    output logic                                   done,
    output logic signed [frgcd_pkg::DATA_WIDTH-1:0] numerator_out,
    output logic signed [frgcd_pkg::DATA_WIDTH-1:0] denominator_out,
    output logic                                   zero_denominator
);
    import frgcd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_EUCLID = 6'b000100,
        S_DIV_N  = 6'b001000,
        S_START_D = 6'b010000,
        S_DIV_D  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    word_t a_reg, a_next;
    word_t b_reg, b_next;
    word_t nmag_reg, nmag_next;
    word_t dmag_reg, dmag_next;
    word_t qn_reg, qn_next;
    logic  neg_reg, neg_next;

    logic  done_reg, done_next;
    word_t num_out_reg, num_out_next;
    word_t den_out_reg, den_out_next;
    logic  zero_reg, zero_next;

    logic  div_start;
    word_t div_dividend;
    word_t div_divisor;
    logic  div_done;
    word_t div_quo;
    word_t div_rem;
    word_t num_mag;
    word_t den_mag;

    frgcd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // input magnitudes
    assign num_mag = numerator_in[DATA_WIDTH-1] ? word_t'(-numerator_in) : word_t'(numerator_in);
    assign den_mag = denominator_in[DATA_WIDTH-1] ? word_t'(-denominator_in)
                                                  : word_t'(denominator_in);

    // divider operand select
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = a_reg;
        div_divisor  = b_reg;
        if (state_reg == S_CHECK)
        begin
            div_start = 1'b1;
            if (b_reg == '0)
            begin
                div_dividend = nmag_reg;
                div_divisor  = a_reg;
            end
        end
        else if (state_reg == S_START_D)
        begin
            div_start    = 1'b1;
            div_dividend = dmag_reg;
            div_divisor  = a_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        nmag_next    = nmag_reg;
        dmag_next    = dmag_reg;
        qn_next      = qn_reg;
        neg_next     = neg_reg;
        done_next    = 1'b0;
        num_out_next = num_out_reg;
        den_out_next = den_out_reg;
        zero_next    = zero_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (denominator_in == '0)
                    begin
                        // undefined fraction passes through
                        done_next    = 1'b1;
                        num_out_next = word_t'(numerator_in);
                        den_out_next = '0;
                        zero_next    = 1'b1;
                    end
                    else
                    begin
                        a_next     = num_mag;
                        b_next     = den_mag;
                        nmag_next  = num_mag;
                        dmag_next  = den_mag;
                        neg_next   = numerator_in[DATA_WIDTH-1] ^ denominator_in[DATA_WIDTH-1];
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                // gcd found once the remainder is zero
                if (b_reg == '0)
                    state_next = S_DIV_N;
                else
                    state_next = S_EUCLID;
            end
            S_EUCLID:
            begin
                if (div_done)
                begin
                    a_next     = b_reg;
                    b_next     = div_rem;
                    state_next = S_CHECK;
                end
            end
            S_DIV_N:
            begin
                if (div_done)
                begin
                    qn_next    = div_quo;
                    state_next = S_START_D;
                end
            end
            S_START_D:
            begin
                state_next = S_DIV_D;
            end
            S_DIV_D:
            begin
                if (div_done)
                begin
                    done_next    = 1'b1;
                    num_out_next = (neg_reg && qn_reg != '0) ? word_t'(-qn_reg) : qn_reg;
                    den_out_next = div_quo;
                    zero_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        nmag_reg    <= nmag_next;
        dmag_reg    <= dmag_next;
        qn_reg      <= qn_next;
        neg_reg     <= neg_next;
        num_out_reg <= num_out_next;
        den_out_reg <= den_out_next;
        zero_reg    <= zero_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign numerator_out    = num_out_reg;
    assign denominator_out  = den_out_reg;
    assign zero_denominator = zero_reg;

endmodule

// ===== tb/fraction_reduce_gcd_top_tb.sv =====
`timescale 1ns / 1ps

module fraction_reduce_gcd_top_tb;

    import frgcd_pkg::*;

    localparam int    RANDOM_ITEMS = 350;
    localparam word_t POS_MAX      = word_t'(32'h7fff_ffff);
    localparam word_t FIB_46       = word_t'(32'd1836311903);
    localparam word_t FIB_45       = word_t'(32'd1134903170);

    // one reduced fraction as the block reports it
    typedef struct packed {
        word_t num;
        word_t den;
        logic  zero_den;
    } fraction_t;

    // expected fractions in arrival order, with the reduction predictor
    class fraction_scoreboard;
        fraction_t expected_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // lowest terms via euclid on the magnitudes, sign moved to the numerator
        function fraction_t reduce_fraction(word_t n, word_t d);
            word_t     nmag;
            word_t     dmag;
            word_t     a;
            word_t     b;
            word_t     r;
            word_t     qn;
            word_t     qd;
            logic      neg;
            fraction_t f;
            if (d == '0) begin
                f.num      = n;
                f.den      = '0;
                f.zero_den = 1'b1;
                return f;
            end
            nmag = n[DATA_WIDTH-1] ? -n : n;
            dmag = d[DATA_WIDTH-1] ? -d : d;
            a = nmag;
            b = dmag;
            while (b != '0) begin
                r = a % b;
                a = b;
                b = r;
            end
            qn  = nmag / a;
            qd  = dmag / a;
            neg = (n[DATA_WIDTH-1] != d[DATA_WIDTH-1]) && (qn != '0);
            f.num      = neg ? -qn : qn;
            f.den      = qd;
            f.zero_den = 1'b0;
            return f;
        endfunction

        // accepted transaction: queue its reduced fraction
        function void note_fraction(word_t n, word_t d);
            expected_q.push_back(reduce_fraction(n, d));
        endfunction

        // compare one strobed result with the oldest expectation
        function void check_fraction(word_t n, word_t d, logic zd);
            fraction_t exp_f;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %0d/%0d zero_denominator=%0b",
                       $signed(n), $signed(d), zd);
                errors++;
                return;
            end
            exp_f = expected_q.pop_front();
            if (n !== exp_f.num) begin
                $error("numerator_out expected %0d actual %0d",
                       $signed(exp_f.num), $signed(n));
                errors++;
            end
            if (d !== exp_f.den) begin
                $error("denominator_out expected %0d actual %0d",
                       $signed(exp_f.den), $signed(d));
                errors++;
            end
            if (zd !== exp_f.zero_den) begin
                $error("zero_denominator expected %0b actual %0b", exp_f.zero_den, zd);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    word_t numerator_in;
    word_t denominator_in;
    logic  done;
    word_t numerator_out;
    word_t denominator_out;
    logic  zero_denominator;

    fraction_scoreboard sb;

    fraction_reduce_gcd_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .numerator_in     (numerator_in),
        .denominator_in   (denominator_in),
        .done             (done),
        .numerator_out    (numerator_out),
        .denominator_out  (denominator_out),
        .zero_denominator (zero_denominator)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_fraction(numerator_out, denominator_out, zero_denominator);
    end

    // magnitude with a random bit length, so small and large values both show up
    function automatic word_t random_magnitude();
        return word_t'($urandom_range(0, 32'h7fff_ffff) >> $urandom_range(0, 30));
    endfunction

    // random sign, never producing the most negative value
    function automatic word_t random_sign(word_t mag);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // present one transaction after a random gap and wait until it is taken
    task automatic send_fraction(input word_t n, input word_t d);
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap)
            begin
                numerator_in   = word_t'($urandom);
                denominator_in = word_t'($urandom);
                @(negedge clk);
            end
        end
        start          = 1'b1;
        numerator_in   = n;
        denominator_in = d;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_fraction(n, d);
    endtask

    // random transaction drawn from a mix of fraction shapes
    task automatic send_random_fraction();
        word_t g;
        word_t x;
        word_t y;
        int    shape;
        shape = $urandom_range(0, 9);
        case (shape)
            0, 1, 2, 3:
            begin
                x = random_magnitude();
                y = random_magnitude();
            end
            4, 5:
            begin
                g = word_t'($urandom_range(2, 65535));
                x = word_t'($urandom_range(0, 32'h7fff_ffff / g)) * g;
                y = word_t'($urandom_range(1, 32'h7fff_ffff / g)) * g;
            end
            6:
            begin
                x = word_t'($urandom_range(0, 20));
                y = word_t'($urandom_range(0, 20));
            end
            7:
            begin
                x = random_magnitude();
                y = '0;
            end
            8:
            begin
                x = '0;
                y = random_magnitude();
            end
            default:
            begin
                y = word_t'($urandom_range(1, 4095));
                x = word_t'($urandom_range(0, 32'h7fff_ffff / y)) * y;
            end
        endcase
        send_fraction(random_sign(x), random_sign(y));
    endtask

    // watchdog
    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        start          = 1'b0;
        numerator_in   = '0;
        denominator_in = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // zero numerator, zero denominator, extremes and sign combinations
        send_fraction('0, word_t'(5));
        send_fraction('0, -word_t'(7));
        send_fraction(word_t'(5), '0);
        send_fraction(-word_t'(5), '0);
        send_fraction('0, '0);
        send_fraction(POS_MAX, '0);
        send_fraction(-POS_MAX, '0);
        send_fraction(POS_MAX, POS_MAX);
        send_fraction(-POS_MAX, POS_MAX);
        send_fraction(POS_MAX, -POS_MAX);
        send_fraction(-POS_MAX, -POS_MAX);
        send_fraction(POS_MAX, word_t'(1));
        send_fraction(-POS_MAX, -word_t'(1));
        send_fraction(word_t'(1), POS_MAX);
        send_fraction(word_t'(1), -word_t'(1));
        send_fraction(-word_t'(1), -word_t'(1));
        send_fraction(word_t'(6), -word_t'(4));
        send_fraction(-word_t'(6), -word_t'(4));
        send_fraction(word_t'(12), word_t'(18));
        send_fraction(POS_MAX, POS_MAX - word_t'(1));
        // consecutive fibonacci numbers give the longest euclid chain
        send_fraction(FIB_46, FIB_45);
        send_fraction(-FIB_45, FIB_46);
        send_fraction(FIB_45, -FIB_46);

        // random transactions
        repeat (RANDOM_ITEMS) send_random_fraction();

        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
